// ----- sv/bvfc_pkg.sv -----
// shared types and constants for the 2d box view culling pipeline
// widths, register indexes and reset values; no dependencies

package bvfc_pkg;

	// field widths
	localparam int COORD_W    = 32;  // box edges and view position
	localparam int OFS_W      = COORD_W + 1;  // corner minus view position
	localparam int ROT_W      = 32;  // cosine and sine, q2.30
	localparam int ROT_FRAC   = 30;
	localparam int PROD_W     = ROT_W + OFS_W;  // one rotation product
	localparam int SUM_W      = PROD_W + 1;  // sum of two products
	localparam int VAL_W      = SUM_W - ROT_FRAC;  // rotated side or depth
	localparam int NEAR_W     = 31;
	localparam int PROJ_W     = 24;
	localparam int PROJ_FRAC  = 16;
	localparam int SX_W       = VAL_W + PROJ_W + 1;  // scaled side
	localparam int CMP_W      = SX_W + 1;  // room for the negated depth
	localparam int CORNERS    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_POS_X  = 3'd0,
		REG_VIEW_POS_Y  = 3'd1,
		REG_VIEW_COSINE = 3'd2,
		REG_VIEW_SINE   = 3'd3,
		REG_NEAR_DEPTH  = 3'd4,
		REG_PROJ_SCALE  = 3'd5
	} cfg_reg_t;

	// reset values
	localparam logic [COORD_W-1:0] RST_VIEW_POS  = '0;
	localparam logic [ROT_W-1:0]   RST_COSINE    = ROT_W'(1) << ROT_FRAC;
	localparam logic [ROT_W-1:0]   RST_SINE      = '0;
	localparam logic [NEAR_W-1:0]  RST_NEAR      = NEAR_W'(65536);
	localparam logic [PROJ_W-1:0]  RST_PROJ      = PROJ_W'(65536);

	// live view configuration
	typedef struct packed {
		logic signed [COORD_W-1:0] view_pos_x;
		logic signed [COORD_W-1:0] view_pos_y;
		logic signed [ROT_W-1:0]   view_cosine;
		logic signed [ROT_W-1:0]   view_sine;
		logic [NEAR_W-1:0]         near_depth;
		logic [PROJ_W-1:0]         proj_scale;
	} cfg_t;

	// rotated corners handed from the rotation to the clip stages
	typedef struct packed {
		logic                             valid;
		logic [CORNERS-1:0][VAL_W-1:0]    side;
		logic [CORNERS-1:0][VAL_W-1:0]    depth;
	} corner_t;

endpackage

// ----- sv/box_view_frustum_cull_2d_unit.sv -----
// top level of the 2d box view culling pipeline
// depends on bvfc_pkg, bvfc_cfg_regs, bvfc_rotate, bvfc_clip

// Culls one axis-aligned 2d box per clock against a view frustum. A box word
// (left, right, top, bottom, signed 16.16) is taken at every edge where start
// is high; busy is always low, so a new box may follow every cycle without a
// gap. done pulses for one cycle with visible valid beside it, in the order
// boxes went in. There is no way to hold results back, so the receiver must
// take every done word as it comes. A box passes through five register
// stages: corner offsets, the eight shared 32x33 rotation products, the
// floored q2.30 sums, the projection scale multiply with the near plane
// test, and the side plane compares. Configuration registers (view position,
// cosine, sine, near depth, projection scale) are written through the cfg
// channel, which is always ready; write them only while no box is in flight,
// since stages 1, 2 and 4 read the live register values.

module box_view_frustum_cull_2d_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// box channel
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_left,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_right,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_top,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_bottom,
	// result channel
	output logic                                   done,
	output logic                                   visible,
	// configuration channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bvfc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bvfc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	bvfc_pkg::cfg_t    cfg;
	bvfc_pkg::corner_t corners;
	logic              accept;

	// fully pipelined, never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// register file, written on any valid cfg word
	bvfc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stages 1-3: translate and rotate the four corners
	bvfc_rotate u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.box_left   (box_left),
		.box_right  (box_right),
		.box_top    (box_top),
		.box_bottom (box_bottom),
		.cfg        (cfg),
		.corners    (corners)
	);

	// stages 4-5: near, left and right plane tests
	bvfc_clip u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.corners (corners),
		.cfg     (cfg),
		.done    (done),
		.visible (visible)
	);

endmodule

// ----- sv/bvfc_cfg_regs.sv -----
// view configuration register file for the box culling pipeline
// depends on bvfc_pkg

module bvfc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [bvfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bvfc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bvfc_pkg::cfg_t                     cfg
);

	bvfc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_pos_x  <= bvfc_pkg::RST_VIEW_POS;
			cfg_q.view_pos_y  <= bvfc_pkg::RST_VIEW_POS;
			cfg_q.view_cosine <= bvfc_pkg::RST_COSINE;
			cfg_q.view_sine   <= bvfc_pkg::RST_SINE;
			cfg_q.near_depth  <= bvfc_pkg::RST_NEAR;
			cfg_q.proj_scale  <= bvfc_pkg::RST_PROJ;
		end else if (cfg_valid) begin
			unique case (bvfc_pkg::cfg_reg_t'(cfg_index))
				bvfc_pkg::REG_VIEW_POS_X:  cfg_q.view_pos_x  <= cfg_data;
				bvfc_pkg::REG_VIEW_POS_Y:  cfg_q.view_pos_y  <= cfg_data;
				bvfc_pkg::REG_VIEW_COSINE: cfg_q.view_cosine <= cfg_data;
				bvfc_pkg::REG_VIEW_SINE:   cfg_q.view_sine   <= cfg_data;
				bvfc_pkg::REG_NEAR_DEPTH:
					cfg_q.near_depth <= cfg_data[bvfc_pkg::NEAR_W-1:0];
				bvfc_pkg::REG_PROJ_SCALE:
					cfg_q.proj_scale <= cfg_data[bvfc_pkg::PROJ_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/bvfc_rotate.sv -----
// stages 1 to 3: corner offsets, rotation products, floored q2.30 sums
// depends on bvfc_pkg

module bvfc_rotate (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_left,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_right,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_top,
	input  logic signed [bvfc_pkg::COORD_W-1:0]    box_bottom,
	input  bvfc_pkg::cfg_t                         cfg,
	output bvfc_pkg::corner_t                      corners
);

	// index 0 is left or top, index 1 is right or bottom
	logic                                  valid_s1;
	logic signed [bvfc_pkg::OFS_W-1:0]     dx_s1 [2];
	logic signed [bvfc_pkg::OFS_W-1:0]     dy_s1 [2];

	logic                                  valid_s2;
	logic signed [bvfc_pkg::PROD_W-1:0]    cos_dx_s2 [2];
	logic signed [bvfc_pkg::PROD_W-1:0]    sin_dx_s2 [2];
	logic signed [bvfc_pkg::PROD_W-1:0]    cos_dy_s2 [2];
	logic signed [bvfc_pkg::PROD_W-1:0]    sin_dy_s2 [2];

	logic                                  valid_s3;
	logic [bvfc_pkg::CORNERS-1:0][bvfc_pkg::VAL_W-1:0] side_s3;
	logic [bvfc_pkg::CORNERS-1:0][bvfc_pkg::VAL_W-1:0] depth_s3;

	logic signed [bvfc_pkg::SUM_W-1:0]     side_sum  [bvfc_pkg::CORNERS];
	logic signed [bvfc_pkg::SUM_W-1:0]     depth_sum [bvfc_pkg::CORNERS];

	// corner order: left-top, right-top, right-bottom, left-bottom
	localparam logic [bvfc_pkg::CORNERS-1:0] X_SEL = 4'b0110;
	localparam logic [bvfc_pkg::CORNERS-1:0] Y_SEL = 4'b1100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: exact 33-bit offsets
	always_ff @(posedge clk) begin
		dx_s1[0] <= bvfc_pkg::OFS_W'(box_left)   - bvfc_pkg::OFS_W'(cfg.view_pos_x);
		dx_s1[1] <= bvfc_pkg::OFS_W'(box_right)  - bvfc_pkg::OFS_W'(cfg.view_pos_x);
		dy_s1[0] <= bvfc_pkg::OFS_W'(box_top)    - bvfc_pkg::OFS_W'(cfg.view_pos_y);
		dy_s1[1] <= bvfc_pkg::OFS_W'(box_bottom) - bvfc_pkg::OFS_W'(cfg.view_pos_y);
	end

	// stage 2: eight 32x33 products, shared across the four corners
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			cos_dx_s2[i] <= cfg.view_cosine * dx_s1[i];
			sin_dx_s2[i] <= cfg.view_sine   * dx_s1[i];
			cos_dy_s2[i] <= cfg.view_cosine * dy_s1[i];
			sin_dy_s2[i] <= cfg.view_sine   * dy_s1[i];
		end
	end

	// stage 3: exact sums, arithmetic shift floors to the coordinate format
	always_comb begin
		for (int c = 0; c < bvfc_pkg::CORNERS; c++) begin
			side_sum[c]  = bvfc_pkg::SUM_W'(cos_dx_s2[X_SEL[c]])
			             - bvfc_pkg::SUM_W'(sin_dy_s2[Y_SEL[c]]);
			depth_sum[c] = bvfc_pkg::SUM_W'(sin_dx_s2[X_SEL[c]])
			             + bvfc_pkg::SUM_W'(cos_dy_s2[Y_SEL[c]]);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < bvfc_pkg::CORNERS; c++) begin
			side_s3[c]  <= side_sum[c][bvfc_pkg::SUM_W-1:bvfc_pkg::ROT_FRAC];
			depth_s3[c] <= depth_sum[c][bvfc_pkg::SUM_W-1:bvfc_pkg::ROT_FRAC];
		end
	end

	assign corners.valid = valid_s3;
	assign corners.side  = side_s3;
	assign corners.depth = depth_s3;

endmodule

// ----- sv/bvfc_clip.sv -----
// stages 4 and 5: near plane test, projection scale and side plane tests
// depends on bvfc_pkg

module bvfc_clip (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bvfc_pkg::corner_t     corners,
	input  bvfc_pkg::cfg_t        cfg,
	output logic                  done,
	output logic                  visible
);

	logic                                  valid_s4;
	logic                                  all_near_s4;
	logic signed [bvfc_pkg::SX_W-1:0]      sx_s4    [bvfc_pkg::CORNERS];
	logic signed [bvfc_pkg::VAL_W-1:0]     depth_s4 [bvfc_pkg::CORNERS];

	logic                                  valid_s5;
	logic                                  visible_s5;

	logic [bvfc_pkg::CORNERS-1:0]          near;
	logic [bvfc_pkg::CORNERS-1:0]          left;
	logic [bvfc_pkg::CORNERS-1:0]          right;
	logic signed [bvfc_pkg::CMP_W-1:0]     w_ext  [bvfc_pkg::CORNERS];
	logic signed [bvfc_pkg::CMP_W-1:0]     sx_ext [bvfc_pkg::CORNERS];

	localparam int W_PAD = bvfc_pkg::CMP_W - bvfc_pkg::VAL_W - bvfc_pkg::PROJ_FRAC;

	always_comb begin
		for (int c = 0; c < bvfc_pkg::CORNERS; c++) begin
			near[c] = $signed(corners.depth[c]) < $signed({1'b0, cfg.near_depth});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= corners.valid;
			valid_s5 <= valid_s4;
		end
	end

	// stage 4: side times projection scale, near plane flag
	always_ff @(posedge clk) begin
		all_near_s4 <= &near;
		for (int c = 0; c < bvfc_pkg::CORNERS; c++) begin
			sx_s4[c]    <= $signed(corners.side[c]) * $signed({1'b0, cfg.proj_scale});
			depth_s4[c] <= $signed(corners.depth[c]);
		end
	end

	// stage 5: compare against plus and minus depth scaled by 2^16
	always_comb begin
		for (int c = 0; c < bvfc_pkg::CORNERS; c++) begin
			w_ext[c]  = {{W_PAD{depth_s4[c][bvfc_pkg::VAL_W-1]}}, depth_s4[c],
			             {bvfc_pkg::PROJ_FRAC{1'b0}}};
			sx_ext[c] = bvfc_pkg::CMP_W'(sx_s4[c]);
			left[c]   = sx_ext[c] < -w_ext[c];
			right[c]  = sx_ext[c] > w_ext[c];
		end
	end

	always_ff @(posedge clk) begin
		visible_s5 <= !(all_near_s4 || (&left) || (&right));
	end

	assign done    = valid_s5;
	assign visible = visible_s5;

endmodule
